>>> rtl/gof_pkg.sv
`timescale 1ns / 1ps
package gof_pkg;

   localparam int GOF_QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      CMD_VTX  = 2'd0,
      CMD_ERR  = 2'd1,
      CMD_QUAD = 2'd2
   } gof_kind_type;

   // One entry from the parser to the vertex generator. A plain vertex uses
   // cx and cy; a quadratic segment uses all three points.
   typedef struct packed {
      gof_kind_type kind;
      logic [31:0]  ax;
      logic [31:0]  ay;
      logic [31:0]  bx;
      logic [31:0]  by;
      logic [31:0]  cx;
      logic [31:0]  cy;
      logic         new_contour;
      logic         first_contour;
      logic         drop_end;
   } gof_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } gof_qstat_type;

endpackage

>>> rtl/glyph_outline_flattener.sv
`timescale 1ns / 1ps
// Channel    Direction  Handshake            Payload
// req_       in         req_valid/req_stall  req_word, req_glyph_start
// rsp_       out        rsp_valid/rsp_stall  rsp_x_coord, rsp_y_coord, flags
//
// The parser takes one request per cycle while the command queue has room.
// A plain vertex or an error is loaded into the result register when it is
// popped from the queue head, once the result register is free; a quadratic
// segment passes the vertex generator states in order: ST_IDLE forms the
// numerators, ST_DIV1 and ST_DIV2 divide by nine (five digits, then four),
// and ST_EMIT1 to ST_EMIT3 emit its vertices, ST_EMIT3 skipped on drop_end.
// Reset is synchronous and clears the parser, queue and result valid.
// A stalled result holds the generator, and a full queue stalls requests.
module glyph_outline_flattener #(
   parameter int QUEUE_DEPTH = gof_pkg::GOF_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_word,
   input  logic               req_glyph_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_x_coord,
   output logic signed [31:0] rsp_y_coord,
   output logic               rsp_new_contour,
   output logic               rsp_first_contour,
   output logic               rsp_last_of_run,
   output logic               rsp_format_error
);
   import gof_pkg::*;

   gof_cmd_type   push_cmd, head_cmd;
   gof_qstat_type stat;
   logic          push, pop, accept;

   assign req_stall = stat.full;
   assign accept    = req_valid && !stat.full;

   gof_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .word        (req_word),
      .glyph_start (req_glyph_start),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   gof_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .stat     (stat)
   );

   gof_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_cmd          (head_cmd),
      .stat              (stat),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_x_coord       (rsp_x_coord),
      .rsp_y_coord       (rsp_y_coord),
      .rsp_new_contour   (rsp_new_contour),
      .rsp_first_contour (rsp_first_contour),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_format_error  (rsp_format_error)
   );

endmodule

>>> rtl/gof_front.sv
`timescale 1ns / 1ps
module gof_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [31:0]       word,
   input  logic              glyph_start,
   output logic              push,
   output gof_pkg::gof_cmd_type push_cmd
);
   import gof_pkg::*;

   typedef enum logic [6:0] {
      PH_CB   = 7'b0000001,
      PH_TYPE = 7'b0000010,
      PH_SX   = 7'b0000100,
      PH_SY   = 7'b0001000,
      PH_REC  = 7'b0010000,
      PH_PX   = 7'b0100000,
      PH_PY   = 7'b1000000
   } phase_type;

   phase_type   phase_ff, phase_in, phase_e;
   logic        err_ff, err_in, err_e;
   logic        first_ff, first_in, first_e;
   logic        ctrl_ff, ctrl_in;
   logic [31:0] bytes_ff, bytes_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] points_ff, points_in;
   logic [31:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [31:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [31:0] ctl_x_ff, ctl_x_in, ctl_y_ff, ctl_y_in;
   logic [31:0] held_x_ff, held_x_in;

   logic [15:0] cnt;
   logic [31:0] rec_size;
   logic [15:0] points_dec;
   logic        last;
   logic [32:0] mid_x, mid_y;
   logic [31:0] c_x, c_y;

   assign phase_e = glyph_start ? PH_CB : phase_ff;
   assign err_e   = glyph_start ? 1'b0 : err_ff;
   assign first_e = glyph_start ? 1'b1 : first_ff;

   assign cnt        = word[31:16];
   assign rec_size   = {13'd0, cnt, 3'd0} + 32'd4;
   assign points_dec = points_ff - 16'd1;
   assign last       = (points_dec == 16'd0);
   assign mid_x      = {ctl_x_ff[31], ctl_x_ff} + {held_x_ff[31], held_x_ff};
   assign mid_y      = {ctl_y_ff[31], ctl_y_ff} + {word[31], word};
   assign c_x        = last ? held_x_ff : mid_x[32:1];
   assign c_y        = last ? word : mid_y[32:1];

   always_comb begin
      phase_in   = phase_ff;
      err_in     = err_ff;
      first_in   = first_ff;
      ctrl_in    = ctrl_ff;
      bytes_in   = bytes_ff;
      kind_in    = kind_ff;
      points_in  = points_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      ctl_x_in   = ctl_x_ff;
      ctl_y_in   = ctl_y_ff;
      held_x_in  = held_x_ff;
      push       = 1'b0;
      push_cmd   = '0;
      push_cmd.ax = cur_x_ff;
      push_cmd.ay = cur_y_ff;
      push_cmd.bx = ctl_x_ff;
      push_cmd.by = ctl_y_ff;
      if (accept) begin
         phase_in = phase_e;
         err_in   = err_e;
         first_in = first_e;
         if (glyph_start) begin
            ctrl_in = 1'b0;
         end
         if (!err_e) begin
            unique case (phase_e)
               PH_CB: begin
                  bytes_in = (word > 32'd16) ? word - 32'd16 : 32'd0;
                  phase_in = PH_TYPE;
               end
               PH_TYPE: begin
                  phase_in = PH_SX;
               end
               PH_SX: begin
                  start_x_in = word;
                  phase_in   = PH_SY;
               end
               PH_SY: begin
                  start_y_in = word;
                  cur_x_in   = start_x_ff;
                  cur_y_in   = word;
                  push       = 1'b1;
                  push_cmd.kind          = CMD_VTX;
                  push_cmd.cx            = start_x_ff;
                  push_cmd.cy            = word;
                  push_cmd.new_contour   = 1'b1;
                  push_cmd.first_contour = first_e;
                  first_in = 1'b0;
                  phase_in = (bytes_ff == 32'd0) ? PH_CB : PH_REC;
               end
               PH_REC: begin
                  if (cnt == 16'd0 || rec_size > bytes_ff) begin
                     err_in        = 1'b1;
                     push          = 1'b1;
                     push_cmd      = '0;
                     push_cmd.kind = CMD_ERR;
                  end else begin
                     bytes_in  = bytes_ff - rec_size;
                     kind_in   = (word[15:0] == 16'd1) ? 2'd1 :
                                 (word[15:0] == 16'd2) ? 2'd2 : 2'd0;
                     points_in = cnt;
                     ctrl_in   = 1'b0;
                     phase_in  = PH_PX;
                  end
               end
               PH_PX: begin
                  held_x_in = word;
                  phase_in  = PH_PY;
               end
               PH_PY: begin
                  points_in = points_dec;
                  if (kind_ff == 2'd1) begin
                     push          = 1'b1;
                     push_cmd.kind = CMD_VTX;
                     push_cmd.cx   = held_x_ff;
                     push_cmd.cy   = word;
                     cur_x_in      = held_x_ff;
                     cur_y_in      = word;
                  end else if (kind_ff == 2'd2) begin
                     if (!ctrl_ff) begin
                        ctl_x_in = held_x_ff;
                        ctl_y_in = word;
                        ctrl_in  = 1'b1;
                     end else begin
                        push              = 1'b1;
                        push_cmd.kind     = CMD_QUAD;
                        push_cmd.cx       = c_x;
                        push_cmd.cy       = c_y;
                        push_cmd.drop_end = last && (bytes_ff == 32'd0) &&
                                            (c_x == start_x_ff) && (c_y == start_y_ff);
                        cur_x_in = c_x;
                        cur_y_in = c_y;
                        ctl_x_in = held_x_ff;
                        ctl_y_in = word;
                     end
                  end
                  if (last) begin
                     phase_in = (bytes_ff == 32'd0) ? PH_CB : PH_REC;
                  end else begin
                     phase_in = PH_PX;
                  end
               end
               default: begin
                  phase_in = PH_CB;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_CB;
         err_ff     <= 1'b0;
         first_ff   <= 1'b1;
         ctrl_ff    <= 1'b0;
         bytes_ff   <= '0;
         kind_ff    <= '0;
         points_ff  <= '0;
         start_x_ff <= '0;
         start_y_ff <= '0;
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         ctl_x_ff   <= '0;
         ctl_y_ff   <= '0;
         held_x_ff  <= '0;
      end else begin
         phase_ff   <= phase_in;
         err_ff     <= err_in;
         first_ff   <= first_in;
         ctrl_ff    <= ctrl_in;
         bytes_ff   <= bytes_in;
         kind_ff    <= kind_in;
         points_ff  <= points_in;
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         ctl_x_ff   <= ctl_x_in;
         ctl_y_ff   <= ctl_y_in;
         held_x_ff  <= held_x_in;
      end
   end

endmodule

>>> rtl/gof_queue.sv
`timescale 1ns / 1ps
module gof_queue #(
   parameter int DEPTH = gof_pkg::GOF_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  gof_pkg::gof_cmd_type  push_cmd,
   input  logic                  pop,
   output gof_pkg::gof_cmd_type  head_cmd,
   output gof_pkg::gof_qstat_type stat
);
   import gof_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   gof_cmd_type   mem [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(DEPTH));
   assign head_cmd   = mem[rd_ff];

   always_comb begin
      wr_in    = push ? inc(wr_ff) : wr_ff;
      rd_in    = pop ? inc(rd_ff) : rd_ff;
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/gof_back.sv
`timescale 1ns / 1ps
module gof_back (
   input  logic                   clock,
   input  logic                   reset,
   input  gof_pkg::gof_cmd_type   head_cmd,
   input  gof_pkg::gof_qstat_type stat,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [31:0]     rsp_x_coord,
   output logic signed [31:0]     rsp_y_coord,
   output logic                   rsp_new_contour,
   output logic                   rsp_first_contour,
   output logic                   rsp_last_of_run,
   output logic                   rsp_format_error
);
   import gof_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DIV1  = 6'b000010,
      ST_DIV2  = 6'b000100,
      ST_EMIT1 = 6'b001000,
      ST_EMIT2 = 6'b010000,
      ST_EMIT3 = 6'b100000
   } state_type;

   // Adding nine times 2^32 keeps the numerator positive and drops out of the
   // low 32 quotient bits; the extra 4 rounds the divide by nine to nearest.
   localparam logic signed [37:0] BIAS = 38'sh9_0000_0004;

   state_type   state_ff, state_in;
   logic [35:0] num_ff [4];
   logic [35:0] num_in [4];
   logic [19:0] qhi_ff [4];
   logic [19:0] qhi_in [4];
   logic [3:0]  rem_ff [4];
   logic [3:0]  rem_in [4];
   logic [31:0] quo_ff [4];
   logic [31:0] quo_in [4];
   logic [31:0] c_x_ff, c_x_in, c_y_ff, c_y_in;
   logic        drop_ff, drop_in;

   logic        out_free, load;
   logic        valid_ff, valid_in;
   logic [31:0] x_ff, x_in, y_ff, y_in;
   logic        nc_ff, nc_in, fc_ff, fc_in, last_ff, last_in, err_ff, err_in;

   function automatic logic [7:0] digit9(input logic [3:0] r, input logic [3:0] d);
      logic [7:0] v;
      logic [3:0] q;
      v = {r, d};
      q = 4'd0;
      for (int k = 1; k < 16; k++) begin
         if (v >= 8'(9 * k)) begin
            q = 4'(k);
         end
      end
      return {q, 4'(v - 8'(9 * q))};
   endfunction

   function automatic logic [23:0] div_hi(input logic [35:0] n);
      logic [3:0]  r;
      logic [19:0] q;
      logic [7:0]  s;
      r = 4'd0;
      q = '0;
      for (int k = 0; k < 5; k++) begin
         s = digit9(r, n[35 - 4 * k -: 4]);
         q = {q[15:0], s[7:4]};
         r = s[3:0];
      end
      return {q, r};
   endfunction

   function automatic logic [15:0] div_lo(input logic [3:0] r0, input logic [15:0] n);
      logic [3:0]  r;
      logic [15:0] q;
      logic [7:0]  s;
      r = r0;
      q = '0;
      for (int k = 0; k < 4; k++) begin
         s = digit9(r, n[15 - 4 * k -: 4]);
         q = {q[11:0], s[7:4]};
         r = s[3:0];
      end
      return q;
   endfunction

   function automatic logic [35:0] numer(input logic [31:0] p, input logic [31:0] q,
                                         input logic [31:0] c, input logic quad_first);
      logic signed [37:0] sp, sq, sc, sum;
      sp = 38'(signed'(p));
      sq = 38'(signed'(q));
      sc = 38'(signed'(c));
      if (quad_first) begin
         sum = (sp <<< 2) + (sq <<< 2) + sc + BIAS;
      end else begin
         sum = sp + (sq <<< 2) + (sc <<< 2) + BIAS;
      end
      return sum[35:0];
   endfunction

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      load     = 1'b0;
      x_in     = x_ff;
      y_in     = y_ff;
      nc_in    = 1'b0;
      fc_in    = 1'b0;
      last_in  = 1'b0;
      err_in   = 1'b0;
      c_x_in   = c_x_ff;
      c_y_in   = c_y_ff;
      drop_in  = drop_ff;
      for (int i = 0; i < 4; i++) begin
         num_in[i] = num_ff[i];
         qhi_in[i] = qhi_ff[i];
         rem_in[i] = rem_ff[i];
         quo_in[i] = quo_ff[i];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (!stat.empty) begin
               if (head_cmd.kind == CMD_QUAD) begin
                  pop       = 1'b1;
                  num_in[0] = numer(head_cmd.ax, head_cmd.bx, head_cmd.cx, 1'b1);
                  num_in[1] = numer(head_cmd.ay, head_cmd.by, head_cmd.cy, 1'b1);
                  num_in[2] = numer(head_cmd.ax, head_cmd.bx, head_cmd.cx, 1'b0);
                  num_in[3] = numer(head_cmd.ay, head_cmd.by, head_cmd.cy, 1'b0);
                  c_x_in    = head_cmd.cx;
                  c_y_in    = head_cmd.cy;
                  drop_in   = head_cmd.drop_end;
                  state_in  = ST_DIV1;
               end else if (out_free) begin
                  pop     = 1'b1;
                  load    = 1'b1;
                  last_in = 1'b1;
                  if (head_cmd.kind == CMD_ERR) begin
                     x_in   = '0;
                     y_in   = '0;
                     err_in = 1'b1;
                  end else begin
                     x_in  = head_cmd.cx;
                     y_in  = head_cmd.cy;
                     nc_in = head_cmd.new_contour;
                     fc_in = head_cmd.first_contour;
                  end
               end
            end
         end
         ST_DIV1: begin
            for (int i = 0; i < 4; i++) begin
               {qhi_in[i], rem_in[i]} = div_hi(num_ff[i]);
            end
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            for (int i = 0; i < 4; i++) begin
               quo_in[i] = {qhi_ff[i][15:0], div_lo(rem_ff[i], num_ff[i][15:0])};
            end
            state_in = ST_EMIT1;
         end
         ST_EMIT1: begin
            if (out_free) begin
               load     = 1'b1;
               x_in     = quo_ff[0];
               y_in     = quo_ff[1];
               state_in = ST_EMIT2;
            end
         end
         ST_EMIT2: begin
            if (out_free) begin
               load     = 1'b1;
               x_in     = quo_ff[2];
               y_in     = quo_ff[3];
               last_in  = drop_ff;
               state_in = drop_ff ? ST_IDLE : ST_EMIT3;
            end
         end
         ST_EMIT3: begin
            if (out_free) begin
               load     = 1'b1;
               x_in     = c_x_ff;
               y_in     = c_y_ff;
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      valid_in = out_free ? load : valid_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         num_ff[i] <= num_in[i];
         qhi_ff[i] <= qhi_in[i];
         rem_ff[i] <= rem_in[i];
         quo_ff[i] <= quo_in[i];
      end
      c_x_ff  <= c_x_in;
      c_y_ff  <= c_y_in;
      drop_ff <= drop_in;
      if (load) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         nc_ff   <= nc_in;
         fc_ff   <= fc_in;
         last_ff <= last_in;
         err_ff  <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_x_coord       = signed'(x_ff);
   assign rsp_y_coord       = signed'(y_ff);
   assign rsp_new_contour   = nc_ff;
   assign rsp_first_contour = fc_ff;
   assign rsp_last_of_run   = last_ff;
   assign rsp_format_error  = err_ff;

endmodule

>>> rtl/gof_checker.sv
`timescale 1ns / 1ps
module gof_assertions (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_x_coord,
   input logic signed [31:0] rsp_y_coord,
   input logic               rsp_new_contour,
   input logic               rsp_first_contour,
   input logic               rsp_last_of_run,
   input logic               rsp_format_error
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_x_coord) && $stable(rsp_y_coord))
      else $error("stalled response changed");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_format_error |-> rsp_x_coord == 0 && rsp_y_coord == 0 &&
      rsp_last_of_run && !rsp_new_contour && !rsp_first_contour)
      else $error("malformed error response");

   a_first_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_first_contour |-> rsp_new_contour && rsp_last_of_run &&
      !rsp_format_error)
      else $error("first contour flag without contour start");

endmodule

bind glyph_outline_flattener gof_assertions u_gof_assertions (.*);
